// ===== src/shell_line_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef SHELL_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slt_pkg.sv =====
// Package with the tokenizer's constants, token kinds, scan states and result type.
`timescale 1ns / 1ps

package slt_pkg;

    localparam int LINE_LEN        = 256;
    localparam int MAX_TOKEN_COUNT = 128;

    localparam int CH_W    = 8;
    localparam int POS_W   = $clog2(LINE_LEN);
    localparam int CNT_W   = $clog2(MAX_TOKEN_COUNT);
    localparam int FIELD_W = 8;
    localparam int KIND_W  = 3;

    // Characters the scanner reacts to.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_DQ    = 8'h22;
    localparam logic [CH_W-1:0] CH_SQ    = 8'h27;
    localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;

    // Token kinds as they appear on the result channel.
    localparam logic [KIND_W-1:0] K_WORD   = 3'd0;
    localparam logic [KIND_W-1:0] K_IN     = 3'd1;
    localparam logic [KIND_W-1:0] K_OUT    = 3'd2;
    localparam logic [KIND_W-1:0] K_APPEND = 3'd3;
    localparam logic [KIND_W-1:0] K_PIPE   = 3'd4;
    localparam logic [KIND_W-1:0] K_END    = 3'd5;

    typedef enum logic [3:0] {
        S_LEAD,
        S_WORD,
        S_GAP,
        S_PIPE,
        S_OUT,
        S_APPEND,
        S_IN,
        S_SQ,
        S_DQ
    } scan_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start_pos;
        logic [FIELD_W-1:0] length;
        logic               open_quote;
        logic               overflow;
        logic               last;
    } token_t;

endpackage

// ===== src/slt_if.sv =====
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
`timescale 1ns / 1ps

interface slt_byte_if;
    logic                      valid;
    logic                      ready;
    logic [slt_pkg::CH_W-1:0]  ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface slt_token_if;
    logic                         valid;
    logic                         ready;
    logic [slt_pkg::KIND_W-1:0]   kind;
    logic [slt_pkg::FIELD_W-1:0]  start_pos;
    logic [slt_pkg::FIELD_W-1:0]  length;
    logic                         open_quote;
    logic                         overflow;
    logic                         last;

    modport source (output valid, output kind, output start_pos, output length,
                    output open_quote, output overflow, output last, input ready);
    modport sink   (input valid, input kind, input start_pos, input length,
                    input open_quote, input overflow, input last, output ready);
endinterface

// ===== src/shell_line_tokenizer.sv =====
// Shell command line tokenizer: one byte in per transaction, tokens out per transaction.
//
// byte_in carries one byte of a command line per transaction; a zero byte ends
// the line. token_out carries one token per transaction: kind, start position
// and length of word content, and on the end token the open-quote and overflow
// flags. last marks the final token caused by one input byte.
// A token caused by a byte is queued on that byte's transaction and offered
// on token_out once it heads the queue. Throughput: one byte per cycle while
// at most one token is queued; a byte that yields two tokens (an operator or
// word followed by the end token) holds ready low. The figure is set by the
// three-entry output queue, which takes at most two tokens per cycle and gives one.
// When the receiver stalls, byte_in keeps accepting while at most one token
// is queued; beyond that ready drops until the queue holds one token or fewer.
// Reset puts the scanner at line start, skipping spaces, with position, token
// count and overflow cleared, and empties the output queue.
// After the end token the next byte begins a new line.
`timescale 1ns / 1ps
`include "shell_line_tokenizer_assert.svh"

module shell_line_tokenizer (
    input logic        clk,
    input logic        rst_n,
    slt_byte_if.sink   byte_in,
    slt_token_if.source token_out
);
    import slt_pkg::*;

    localparam int Q_DEPTH = 3;
    localparam int Q_CNT_W = 2;

    scan_state_t        state_reg, state_next;
    logic [POS_W-1:0]   ws_reg, ws_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   tc_reg, tc_next;
    logic               ovf_reg, ovf_next;

    token_t             q_reg [Q_DEPTH];
    token_t             q_next [Q_DEPTH];
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    logic               accept;
    logic               pop;

    // Scanner decode results.
    logic               tok_v;
    logic               end_v;
    token_t             tok;
    token_t             end_tok;

    assign accept        = byte_in.valid && byte_in.ready;
    assign pop           = token_out.valid && token_out.ready;
    assign byte_in.ready = (cnt_reg <= Q_CNT_W'(1));

    always_comb
    begin
        logic [CH_W-1:0]    c;
        scan_state_t        st;
        logic [POS_W-1:0]   ws;
        logic [POS_W-1:0]   p;
        logic [CNT_W-1:0]   tc;
        logic               ovf;
        logic               skip;
        logic               emit_req;
        logic [KIND_W-1:0]  e_kind;
        logic [POS_W-1:0]   e_start;
        logic [POS_W-1:0]   e_len;
        logic               after_op;
        logic               oq;

        c        = (pos_reg == POS_W'(LINE_LEN - 1)) ? CH_NUL : byte_in.ch;
        st       = state_reg;
        ws       = ws_reg;
        p        = pos_reg;
        tc       = tc_reg;
        ovf      = ovf_reg;
        skip     = 1'b0;
        emit_req = 1'b0;
        e_kind   = K_WORD;
        e_start  = '0;
        e_len    = '0;
        after_op = 1'b0;
        end_v    = 1'b0;
        oq       = 1'b0;
        tok_v    = 1'b0;

        if (st == S_LEAD)
        begin
            if (c == CH_SPACE)
            begin
                skip = 1'b1;
            end
            else
            begin
                ws = pos_reg;
                st = S_WORD;
            end
        end

        if (!skip)
        begin
            case (st)
                S_WORD:
                begin
                    if (c == CH_SPACE || c == CH_GT || c == CH_LT || c == CH_PIPE ||
                        c == CH_NUL)
                    begin
                        emit_req = 1'b1;
                        e_kind   = K_WORD;
                        e_start  = ws;
                        e_len    = pos_reg - ws;
                        case (c)
                            CH_SPACE: st = S_GAP;
                            CH_GT:    st = S_OUT;
                            CH_LT:    st = S_IN;
                            CH_PIPE:  st = S_PIPE;
                            default:  end_v = 1'b1;
                        endcase
                    end
                end
                S_GAP:
                begin
                    case (c)
                        CH_GT:    st = S_OUT;
                        CH_LT:    st = S_IN;
                        CH_PIPE:  st = S_PIPE;
                        CH_SPACE: st = S_GAP;
                        CH_SQ:
                        begin
                            ws = pos_reg + POS_W'(1);
                            st = S_SQ;
                        end
                        CH_DQ:
                        begin
                            ws = pos_reg + POS_W'(1);
                            st = S_DQ;
                        end
                        CH_NUL:   end_v = 1'b1;
                        default:
                        begin
                            ws = pos_reg;
                            st = S_WORD;
                        end
                    endcase
                end
                S_SQ, S_DQ:
                begin
                    if (c == CH_NUL)
                    begin
                        end_v = 1'b1;
                        oq    = 1'b1;
                    end
                    else if ((st == S_SQ && c == CH_SQ) || (st == S_DQ && c == CH_DQ))
                    begin
                        emit_req = 1'b1;
                        e_kind   = K_WORD;
                        e_start  = ws;
                        e_len    = pos_reg - ws;
                        st       = S_GAP;
                    end
                end
                S_PIPE:
                begin
                    emit_req = 1'b1;
                    e_kind   = K_PIPE;
                    after_op = 1'b1;
                end
                S_IN:
                begin
                    emit_req = 1'b1;
                    e_kind   = K_IN;
                    after_op = 1'b1;
                end
                S_OUT:
                begin
                    if (c == CH_GT)
                    begin
                        st = S_APPEND;
                    end
                    else
                    begin
                        emit_req = 1'b1;
                        e_kind   = K_OUT;
                        after_op = 1'b1;
                    end
                end
                S_APPEND:
                begin
                    emit_req = 1'b1;
                    e_kind   = K_APPEND;
                    after_op = 1'b1;
                end
                default:
                begin
                    st  = S_LEAD;
                    ws  = '0;
                    p   = '0;
                    tc  = '0;
                    ovf = 1'b0;
                end
            endcase
        end

        // The byte after an operator opens a bare word unless it is a space or the zero byte, which ends the line.
        if (after_op)
        begin
            if (c == CH_NUL)
            begin
                end_v = 1'b1;
            end
            else if (c == CH_SPACE)
            begin
                st = S_GAP;
            end
            else
            begin
                ws = pos_reg;
                st = S_WORD;
            end
        end

        // One slot is always kept for the end token.
        if (emit_req)
        begin
            if (tc == CNT_W'(MAX_TOKEN_COUNT - 1))
            begin
                ovf = 1'b1;
            end
            else
            begin
                tok_v = 1'b1;
                tc    = tc + CNT_W'(1);
            end
        end

        tok.kind       = e_kind;
        tok.start_pos  = FIELD_W'(e_start);
        tok.length     = FIELD_W'(e_len);
        tok.open_quote = 1'b0;
        tok.overflow   = 1'b0;
        tok.last       = !end_v;

        end_tok.kind       = K_END;
        end_tok.start_pos  = '0;
        end_tok.length     = '0;
        end_tok.open_quote = oq;
        end_tok.overflow   = ovf;
        end_tok.last       = 1'b1;

        if (end_v)
        begin
            state_next = S_LEAD;
            ws_next    = '0;
            pos_next   = '0;
            tc_next    = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            state_next = st;
            ws_next    = ws;
            pos_next   = p + POS_W'(1);
            tc_next    = tc;
            ovf_next   = ovf;
        end
    end

    // Output queue: entry 0 is the head shown on token_out.
    always_comb
    begin
        logic [Q_CNT_W-1:0] cnt_p;
        logic               push_a;
        logic               push_b;
        token_t             res_a;

        q_next = q_reg;
        cnt_p  = cnt_reg;
        if (pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
            cnt_p = cnt_reg - Q_CNT_W'(1);
        end

        push_a = accept && (tok_v || end_v);
        push_b = accept && tok_v && end_v;
        res_a  = tok_v ? tok : end_tok;

        for (int i = 0; i < Q_DEPTH; i++)
        begin
            if (push_a && cnt_p == Q_CNT_W'(i))
            begin
                q_next[i] = res_a;
            end
            if (push_b && (cnt_p + Q_CNT_W'(1)) == Q_CNT_W'(i))
            begin
                q_next[i] = end_tok;
            end
        end

        cnt_next = cnt_p + Q_CNT_W'(push_a) + Q_CNT_W'(push_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LEAD;
            ws_reg    <= '0;
            pos_reg   <= '0;
            tc_reg    <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                ws_reg    <= ws_next;
                pos_reg   <= pos_next;
                tc_reg    <= tc_next;
                ovf_reg   <= ovf_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign token_out.valid      = (cnt_reg != '0);
    assign token_out.kind       = q_reg[0].kind;
    assign token_out.start_pos  = q_reg[0].start_pos;
    assign token_out.length     = q_reg[0].length;
    assign token_out.open_quote = q_reg[0].open_quote;
    assign token_out.overflow   = q_reg[0].overflow;
    assign token_out.last       = q_reg[0].last;

    `SLT_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
    `SLT_ASSERT_NEXT(a_line_restart, clk, rst_n, accept && end_v, pos_reg == '0 && tc_reg == '0 && state_reg == S_LEAD, "line end did not restart the scanner")
    `SLT_ASSERT_IMPL(a_lead_clean, clk, rst_n, state_reg == S_LEAD, tc_reg == '0 && !ovf_reg, "line start with stale token count")
    `SLT_ASSERT_IMPL(a_end_last, clk, rst_n, token_out.valid && token_out.kind == K_END, token_out.last, "end token not marked last")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the shell line tokenizer: byte stream in, checked tokens out.
`timescale 1ns / 1ps

module testbench;
    import slt_pkg::*;

    localparam logic [CH_W-1:0] CH_A = "a";
    localparam logic [CH_W-1:0] CH_Z = "z";

    // Predicts the tokens of each accepted byte and checks what comes out.
    class token_scoreboard;
        scan_state_t        state;
        logic [FIELD_W-1:0] word_start;
        logic [FIELD_W-1:0] position;
        int unsigned        token_count;
        bit                 overflow_seen;
        token_t             step_q[$];
        token_t             expected_q[$];
        int unsigned        errors;

        function new();
            clear_line();
            errors = 0;
        endfunction

        function void clear_line();
            state         = S_LEAD;
            word_start    = '0;
            position      = '0;
            token_count   = 0;
            overflow_seen = 1'b0;
        endfunction

        // One slot is always held back for the end token.
        function void add_token(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] st,
                                logic [FIELD_W-1:0] len);
            if (token_count + 1 >= MAX_TOKEN_COUNT)
            begin
                overflow_seen = 1'b1;
            end
            else
            begin
                token_count++;
                step_q.push_back('{kind, st, len, 1'b0, 1'b0, 1'b0});
            end
        endfunction

        function void finish_line(bit open_q);
            step_q.push_back('{K_END, '0, '0, open_q, overflow_seen, 1'b0});
            clear_line();
        endfunction

        // Handles the byte following an operator; returns 1 when the line ended.
        function bit after_operator(logic [CH_W-1:0] c);
            if (c == CH_NUL)
            begin
                finish_line(1'b0);
                return 1'b1;
            end
            if (c == CH_SPACE)
            begin
                state = S_GAP;
            end
            else
            begin
                word_start = position;
                state      = S_WORD;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [CH_W-1:0] ch_in);
            logic [CH_W-1:0] c;
            bit              ended;
            c     = ch_in;
            ended = 1'b0;
            step_q.delete();
            // An over-long line is cut off at the last position.
            if (position >= LINE_LEN - 1)
            begin
                c = CH_NUL;
            end
            if (state == S_LEAD)
            begin
                if (c == CH_SPACE)
                begin
                    position++;
                    return;
                end
                word_start = position;
                state      = S_WORD;
            end
            case (state)
                S_WORD:
                begin
                    if (c == CH_SPACE || c == CH_GT || c == CH_LT || c == CH_PIPE
                        || c == CH_NUL)
                    begin
                        add_token(K_WORD, word_start, position - word_start);
                        if (c == CH_SPACE) state = S_GAP;
                        else if (c == CH_GT) state = S_OUT;
                        else if (c == CH_LT) state = S_IN;
                        else if (c == CH_PIPE) state = S_PIPE;
                        else
                        begin
                            finish_line(1'b0);
                            ended = 1'b1;
                        end
                    end
                end
                S_GAP:
                begin
                    if (c == CH_GT) state = S_OUT;
                    else if (c == CH_LT) state = S_IN;
                    else if (c == CH_PIPE) state = S_PIPE;
                    else if (c == CH_SPACE) state = S_GAP;
                    else if (c == CH_SQ)
                    begin
                        word_start = position + 1'b1;
                        state      = S_SQ;
                    end
                    else if (c == CH_DQ)
                    begin
                        word_start = position + 1'b1;
                        state      = S_DQ;
                    end
                    else if (c == CH_NUL)
                    begin
                        finish_line(1'b0);
                        ended = 1'b1;
                    end
                    else
                    begin
                        word_start = position;
                        state      = S_WORD;
                    end
                end
                S_SQ, S_DQ:
                begin
                    if (c == CH_NUL)
                    begin
                        finish_line(1'b1);
                        ended = 1'b1;
                    end
                    else if ((state == S_SQ && c == CH_SQ) ||
                             (state == S_DQ && c == CH_DQ))
                    begin
                        add_token(K_WORD, word_start, position - word_start);
                        state = S_GAP;
                    end
                end
                S_PIPE:
                begin
                    add_token(K_PIPE, '0, '0);
                    ended = after_operator(c);
                end
                S_IN:
                begin
                    add_token(K_IN, '0, '0);
                    ended = after_operator(c);
                end
                S_OUT:
                begin
                    if (c == CH_GT)
                    begin
                        state = S_APPEND;
                    end
                    else
                    begin
                        add_token(K_OUT, '0, '0);
                        ended = after_operator(c);
                    end
                end
                S_APPEND:
                begin
                    add_token(K_APPEND, '0, '0);
                    ended = after_operator(c);
                end
                default: clear_line();
            endcase
            if (!ended)
            begin
                position++;
            end
            if (step_q.size() != 0)
            begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
            foreach (step_q[i])
            begin
                expected_q.push_back(step_q[i]);
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
            if (got !== want)
            begin
                report($sformatf("%s is %0h, expected %0h", name, got, want));
            end
        endtask

        task check_token(token_t got);
            token_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected token, kind %0d", got.kind));
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", FIELD_W'(got.kind), FIELD_W'(want.kind));
            check_field("start_pos", got.start_pos, want.start_pos);
            check_field("length", got.length, want.length);
            check_field("open_quote", FIELD_W'(got.open_quote), FIELD_W'(want.open_quote));
            check_field("overflow", FIELD_W'(got.overflow), FIELD_W'(want.overflow));
            check_field("last", FIELD_W'(got.last), FIELD_W'(want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    slt_byte_if  byte_if ();
    slt_token_if tok_if ();

    shell_line_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_if),
        .token_out (tok_if)
    );

    token_scoreboard sb;
    logic [CH_W-1:0] stim_q[$];
    int unsigned     send_gap_max;
    int unsigned     recv_stall_max;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            stim_q.push_back(s[i]);
        end
    endfunction

    function automatic logic [CH_W-1:0] plain_char();
        case ($urandom_range(0, 9))
            0: return CH_SQ;
            1: return CH_DQ;
            2: return CH_W'($urandom_range(128, 255));
            default: return CH_W'($urandom_range(CH_A, CH_Z));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] operator_char();
        case ($urandom_range(0, 2))
            0: return CH_LT;
            1: return CH_GT;
            default: return CH_PIPE;
        endcase
    endfunction

    // A mostly well-formed command line with random content.
    function automatic void build_line();
        logic [CH_W-1:0] quote;
        logic [CH_W-1:0] c;
        repeat ($urandom_range(0, 2)) stim_q.push_back(CH_SPACE);
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 5))
                0, 1: repeat ($urandom_range(1, 5)) stim_q.push_back(plain_char());
                2:
                begin
                    quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                    stim_q.push_back(CH_SPACE);
                    stim_q.push_back(quote);
                    repeat ($urandom_range(0, 4))
                    begin
                        do c = CH_W'($urandom_range(1, 255)); while (c == quote);
                        stim_q.push_back(c);
                    end
                    // Now and then the quote is left open.
                    if ($urandom_range(0, 7) != 0) stim_q.push_back(quote);
                end
                3:
                begin
                    stim_q.push_back(operator_char());
                    if ($urandom_range(0, 3) == 0) stim_q.push_back(CH_GT);
                    if ($urandom_range(0, 1) != 0) stim_q.push_back(CH_SPACE);
                end
                4: repeat ($urandom_range(1, 2)) stim_q.push_back(CH_SPACE);
                default:
                begin
                    stim_q.push_back(operator_char());
                    stim_q.push_back(plain_char());
                end
            endcase
        end
        stim_q.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [CH_W-1:0] c);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.ch    <= c;
        @(posedge clk);
        while (!byte_if.ready) @(posedge clk);
        sb.note_byte(c);
    endtask

    task automatic send_buffer(inout int unsigned sent);
        foreach (stim_q[i])
        begin
            send_byte(stim_q[i]);
        end
        sent += stim_q.size();
        stim_q.delete();
    endtask

    // Token receiver with random back-pressure.
    initial
    begin
        int unsigned stall;
        token_t      got;
        tok_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, recv_stall_max);
            if (stall != 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            @(posedge clk);
            while (!tok_if.valid) @(posedge clk);
            got = '{tok_if.kind, tok_if.start_pos, tok_if.length, tok_if.open_quote,
                    tok_if.overflow, tok_if.last};
            sb.check_token(got);
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase_sent;
        rst_n          = 1'b0;
        byte_if.valid  = 1'b0;
        byte_if.ch     = '0;
        sb             = new();
        send_gap_max   = 6;
        recv_stall_max = 6;
        sent           = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Quote at line start, zero inside a double quote.
        push_text("'q \"z");
        stim_q.push_back(CH_NUL);
        // Append, input and pipe operators, zero right after a pipe.
        push_text("a>>b<c|");
        stim_q.push_back(CH_NUL);
        // Highest byte value as a word, zero right after an output redirect.
        stim_q.push_back(CH_SPACE);
        stim_q.push_back(8'hFF);
        stim_q.push_back(CH_GT);
        stim_q.push_back(CH_NUL);
        // Empty single-quoted word.
        push_text("x ''");
        stim_q.push_back(CH_NUL);
        // A line of only spaces gives one empty word.
        stim_q.push_back(CH_SPACE);
        stim_q.push_back(CH_NUL);
        send_buffer(sent);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_max   = (phase == 1 || phase == 3) ? 6 : 0;
            recv_stall_max = (phase == 2 || phase == 3) ? 6 : 0;
            phase_sent     = sent;
            if (phase == 1)
            begin
                // Dense operators: one token per byte runs past the token limit.
                repeat (100)
                begin
                    stim_q.push_back(CH_W'($urandom_range(CH_A, CH_Z)));
                    stim_q.push_back(operator_char());
                end
                stim_q.push_back(CH_NUL);
                send_buffer(sent);
            end
            if (phase == 2)
            begin
                // 300 nonzero bytes before the zero byte: the line is cut at the last position.
                repeat (300) stim_q.push_back(CH_W'($urandom_range(1, 255)));
                stim_q.push_back(CH_NUL);
                send_buffer(sent);
            end
            while (sent - phase_sent < 200)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    repeat ($urandom_range(1, 12))
                        stim_q.push_back(CH_W'($urandom_range(0, 255)));
                end
                else
                begin
                    build_line();
                end
                send_buffer(sent);
            end
        end
        byte_if.valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/slt_pkg.sv
src/slt_if.sv
src/shell_line_tokenizer.sv
dv/testbench.sv
